@@ src/mmat_pkg.sv @@
// ----------------------------------------------------------------------------
// MIDI message assembler package
// Shared constants, the result record and the status-byte length rule.
// ----------------------------------------------------------------------------
package mmat_pkg;

    localparam logic [7:0] SYSEX_START  = 8'hF0;
    localparam logic [7:0] SYSEX_END    = 8'hF7;
    localparam logic [7:0] SONG_SELECT  = 8'hF3;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_PRESSURE = 4'hD;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [7:0] CC_CHAN0     = 8'hB0;
    localparam logic [7:0] CC_REMAP_MAX = 8'd9;
    localparam logic [7:0] CC_REMAP_ADD = 8'h10;
    localparam int         NOTE_MAX     = 127;
    localparam int         NOTE_COUNT   = 128;
    localparam int         NOTE_W       = 7;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_TRANSPOSE_ACTIVE  = 2'd0,
        CFG_TRANSPOSE_OCTAVES = 2'd1,
        CFG_CONTROLLER_STREAM = 2'd2
    } cfg_index_t;

    // message length codes, zero means sysex start
    typedef enum logic [1:0] {
        LEN_SYSEX = 2'd0,
        LEN_ONE   = 2'd1,
        LEN_TWO   = 2'd2,
        LEN_THREE = 2'd3
    } msg_len_t;

    typedef struct packed {
        logic       out_kind;
        logic [7:0] status_byte;
        logic [7:0] data_one;
        logic [7:0] data_two;
        logic [1:0] msg_length;
        logic       sysex_end;
    } result_t;

    function automatic msg_len_t length_of(input logic [7:0] b);
        msg_len_t len;
        if (b == SYSEX_START) begin
            len = LEN_SYSEX;
        end else if (b[7:4] == NIB_SYSTEM && !(b[3:0] inside {4'h0, 4'h2, 4'h3})) begin
            len = LEN_ONE;
        end else if (b[7:4] == NIB_PROGRAM || b[7:4] == NIB_PRESSURE
                     || b == SONG_SELECT) begin
            len = LEN_TWO;
        end else begin
            len = LEN_THREE;
        end
        return len;
    endfunction

endpackage

@@ src/midi_message_assembler_transposer_core.sv @@
// ----------------------------------------------------------------------------
// MIDI message assembler / transposer core
// Rebuilds short MIDI messages from a byte stream, streams sysex bytes and
// optionally transposes notes and remaps low controller numbers.
// ----------------------------------------------------------------------------
// Takes one raw MIDI byte per transfer and, while s_ready is high, accepts
// a new byte every cycle. A complete short message (length from its first
// byte, no running status) leaves as one registered result transfer; each
// byte from 0xF0 through the closing 0xF7 leaves as its own sysex transfer
// with the end flag on 0xF7. With transposition on, note-on numbers shift by
// octaves*12 (clamped to 0..127) and are remembered per original note so
// that the matching note-off gets the same shifted number; on the controller
// stream, CC 0..9 on status 0xB0 gain 0x10. The per-note table keeps its
// valid bits in flip-flops (all clear after reset, no clearing pass) and its
// note values in a 128 x 7 memory that is read when the second byte of a
// message arrives, so the data is ready when the third byte completes it.
// Throughput is one byte per cycle while s_ready is high. A two-entry output
// stage (result register plus skid register) keeps s_ready a registered
// signal; s_ready drops only while both entries hold undelivered results.
// Configuration is written through cfg_wr_en/cfg_index/cfg_data and should
// change only while the core is idle.
// ----------------------------------------------------------------------------
module midi_message_assembler_transposer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data,
    // byte input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_out_kind,
    output logic [7:0]  m_status_byte,
    output logic [7:0]  m_data_one,
    output logic [7:0]  m_data_two,
    output logic [1:0]  m_msg_length,
    output logic        m_sysex_end
);
    import mmat_pkg::*;

    // configuration
    logic              transpose_active_reg;
    logic signed [3:0] transpose_octaves_reg;
    logic              controller_stream_reg;

    // parser state
    logic [1:0] held_count_reg,  held_count_next;
    logic [7:0] held_first_reg,  held_first_next;
    logic [7:0] held_second_reg, held_second_next;
    logic       in_sysex_reg,    in_sysex_next;

    // note table: valid bits in flops, values in memory
    logic [NOTE_COUNT-1:0] note_valid_reg;
    logic [NOTE_W-1:0]     note_mem [NOTE_COUNT];
    logic [NOTE_W-1:0]     note_rd_reg;

    // output stage
    result_t out_reg,  skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    logic     accept, pop, push;
    result_t  res;
    msg_len_t in_len, held_len;

    logic              note_on_hit, note_off_hit, is_cc_remap, note_in_range;
    logic signed [9:0] oct_ext, oct_shift, note_sum;
    logic [NOTE_W-1:0] note_clamped;
    logic [7:0]        d1_xform;
    logic              tbl_wr, tbl_clr, tbl_rd;
    logic [NOTE_W-1:0] tbl_idx;

    assign accept = s_valid && s_ready;
    assign pop    = out_valid_reg && m_ready;
    assign s_ready = !skid_valid_reg;

    assign in_len   = length_of(s_in_byte);
    assign held_len = length_of(held_first_reg);

    // ------------------------------------------------------------------
    // Transform of the second byte of a 3-byte message
    // ------------------------------------------------------------------
    assign note_in_range = !held_second_reg[7];
    assign tbl_idx       = held_second_reg[NOTE_W-1:0];
    assign note_on_hit   = transpose_active_reg && held_first_reg[7:4] == NIB_NOTE_ON;
    assign note_off_hit  = transpose_active_reg && held_first_reg[7:4] == NIB_NOTE_OFF;
    assign is_cc_remap   = transpose_active_reg && controller_stream_reg
                           && held_first_reg == CC_CHAN0
                           && held_second_reg <= CC_REMAP_MAX;

    // octaves * 12 = octaves * 8 + octaves * 4
    assign oct_ext   = 10'(transpose_octaves_reg);
    assign oct_shift = (oct_ext <<< 3) + (oct_ext <<< 2);
    assign note_sum  = signed'({2'b00, held_second_reg}) + oct_shift;

    always_comb begin
        if (note_sum < 0) begin
            note_clamped = '0;
        end else if (note_sum > 10'(NOTE_MAX)) begin
            note_clamped = NOTE_W'(NOTE_MAX);
        end else begin
            note_clamped = note_sum[NOTE_W-1:0];
        end
    end

    always_comb begin
        if (note_on_hit) begin
            d1_xform = {1'b0, note_clamped};
        end else if (note_off_hit && note_in_range && note_valid_reg[tbl_idx]) begin
            d1_xform = {1'b0, note_rd_reg};
        end else if (is_cc_remap) begin
            d1_xform = held_second_reg + CC_REMAP_ADD;
        end else begin
            d1_xform = held_second_reg;
        end
    end

    // ------------------------------------------------------------------
    // Parser: next state and result of the current byte
    // ------------------------------------------------------------------
    always_comb begin
        held_count_next  = held_count_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        in_sysex_next    = in_sysex_reg;
        push             = 1'b0;
        res              = '0;
        tbl_wr           = 1'b0;
        tbl_clr          = 1'b0;
        tbl_rd           = 1'b0;

        if (in_sysex_reg) begin
            push            = 1'b1;
            res.out_kind    = 1'b1;
            res.status_byte = s_in_byte;
            res.sysex_end   = (s_in_byte == SYSEX_END);
            if (s_in_byte == SYSEX_END) begin
                in_sysex_next = 1'b0;
            end
        end else if (held_count_reg == 2'd0) begin
            case (in_len)
                LEN_SYSEX: begin
                    in_sysex_next   = 1'b1;
                    push            = 1'b1;
                    res.out_kind    = 1'b1;
                    res.status_byte = s_in_byte;
                end
                LEN_ONE: begin
                    push            = 1'b1;
                    res.status_byte = s_in_byte;
                    res.msg_length  = LEN_ONE;
                end
                default: begin
                    held_first_next = s_in_byte;
                    held_count_next = 2'd1;
                end
            endcase
        end else if (held_count_reg == 2'd1) begin
            if (held_len == LEN_TWO) begin
                // 2-byte messages never match a transform rule
                held_count_next = 2'd0;
                push            = 1'b1;
                res.status_byte = held_first_reg;
                res.data_one    = s_in_byte;
                res.msg_length  = LEN_TWO;
            end else begin
                held_second_next = s_in_byte;
                held_count_next  = 2'd2;
                tbl_rd           = 1'b1;   // fetch stored note ahead of the third byte
            end
        end else begin
            held_count_next = 2'd0;
            push            = 1'b1;
            res.status_byte = held_first_reg;
            res.data_one    = d1_xform;
            res.data_two    = s_in_byte;
            res.msg_length  = LEN_THREE;
            tbl_wr          = note_on_hit && note_in_range;
            tbl_clr         = note_off_hit && note_in_range && note_valid_reg[tbl_idx];
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            transpose_active_reg  <= 1'b0;
            transpose_octaves_reg <= '0;
            controller_stream_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_TRANSPOSE_ACTIVE:  transpose_active_reg  <= cfg_data[0];
                CFG_TRANSPOSE_OCTAVES: transpose_octaves_reg <= signed'(cfg_data);
                CFG_CONTROLLER_STREAM: controller_stream_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Parser state and note valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg  <= '0;
            held_first_reg  <= '0;
            held_second_reg <= '0;
            in_sysex_reg    <= 1'b0;
            note_valid_reg  <= '0;
        end else if (accept) begin
            held_count_reg  <= held_count_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            in_sysex_reg    <= in_sysex_next;
            if (tbl_wr) begin
                note_valid_reg[tbl_idx] <= 1'b1;
            end else if (tbl_clr) begin
                note_valid_reg[tbl_idx] <= 1'b0;
            end
        end
    end

    // note value memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (accept && tbl_wr) begin
            note_mem[tbl_idx] <= note_clamped;
        end
        if (accept && tbl_rd) begin
            note_rd_reg <= note_mem[s_in_byte[NOTE_W-1:0]];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: result register plus skid register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg) begin
                out_valid_reg <= accept && push;
            end else if (pop) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept && push;
                end
            end else if (accept && push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || (pop && !skid_valid_reg)) begin
            out_reg <= res;
        end else if (pop) begin
            out_reg <= skid_reg;
        end
        if (out_valid_reg && !pop && !skid_valid_reg) begin
            skid_reg <= res;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_out_kind    = out_reg.out_kind;
    assign m_status_byte = out_reg.status_byte;
    assign m_data_one    = out_reg.data_one;
    assign m_data_two    = out_reg.data_two;
    assign m_msg_length  = out_reg.msg_length;
    assign m_sysex_end   = out_reg.sysex_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // skid entry only ever sits behind a full result register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a result while result register is empty");

    // no short message is held while streaming sysex
    a_sysex_no_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_sysex_reg |-> held_count_reg == 2'd0)
        else $error("held bytes present inside sysex");

    // a stalled result plus a new one must land in the skid register
    a_stall_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && push && out_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("result lost during output stall");

    // a completed message returns the parser to its idle count
    a_len3_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && held_count_reg == 2'd2) |=> held_count_reg == 2'd0)
        else $error("held count not cleared after 3-byte message");

endmodule

@@ verif/midi_message_assembler_transposer_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI message assembler / transposer core testbench
// Feeds raw MIDI byte streams through the core under several register
// settings and handshake idling patterns. Every expected message or sysex
// byte is predicted on the input transfer and checked field by field against
// the result transfers.
// ----------------------------------------------------------------------------
module midi_message_assembler_transposer_core_test;
    import mmat_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int SETTLE_CYCLES  = 4;       // settling margin after a drain
    localparam int TIMEOUT_NS     = 500_000;
    localparam int ITEMS_PER_SET  = 125;
    localparam int SEMITONES      = 12;
    localparam int MAX_ERR_LINES  = 200;

    localparam logic       KIND_SHORT      = 1'b0;
    localparam logic       KIND_SYSEX      = 1'b1;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;   // no register behind it
    localparam logic [7:0] SONG_POSITION   = 8'hF2;  // system common, 3 bytes

    // notes for the random traffic, picked so that on/off pairs meet and
    // both clamp limits are hit at +/-4 octaves
    localparam logic [7:0] NOTE_POOL [8] = '{8'd0, 8'd20, 8'd47, 8'd60,
                                             8'd64, 8'd80, 8'd100, 8'd127};

    // plain parsing corner cases, transposition off
    localparam logic [7:0] PLAIN_BYTES [15] = '{
        8'h00, 8'h7F, 8'hFF,                   // data byte opens a 3-byte message
        8'hC5, 8'h80,                          // program change, status as data
        SONG_SELECT, 8'h12,
        8'hF8,                                 // realtime, single byte
        SYSEX_END,                             // lone F7 outside sysex
        8'h90, SYSEX_START, 8'h40,             // F0 held as a data byte
        SYSEX_START, SYSEX_START, SYSEX_END    // F0 inside sysex is plain data
    };

    // transposition corner cases, run at octave -8
    localparam logic [7:0] XPOSE_BYTES [12] = '{
        8'h90, 8'h10, 8'h40,                   // clamps to 0, stored
        8'h80, 8'h10, 8'h00,                   // picks up stored note
        CC_CHAN0, 8'h09, 8'h7F,                // remapped controller
        8'h90, 8'h85, 8'h10                    // note above 127, no table use
    };

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       cfg_wr_en     = 1'b0;
    logic [1:0] cfg_index     = 2'd0;
    logic [3:0] cfg_data      = 4'd0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte     = 8'h00;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_out_kind;
    logic [7:0] m_status_byte;
    logic [7:0] m_data_one;
    logic [7:0] m_data_two;
    logic [1:0] m_msg_length;
    logic       m_sysex_end;

    midi_message_assembler_transposer_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_kind    (m_out_kind),
        .m_status_byte (m_status_byte),
        .m_data_one    (m_data_one),
        .m_data_two    (m_data_two),
        .m_msg_length  (m_msg_length),
        .m_sysex_end   (m_sysex_end)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ------------------------------------------------------------------
    // stimulus bookkeeping and handshake pressure knobs
    // ------------------------------------------------------------------
    logic [7:0] midi_bytes_out[$];     // bytes waiting for the driver
    result_t    expected_msgs[$];      // predicted results, oldest first
    int         bytes_queued    = 0;
    int         bytes_sent      = 0;
    int         mismatch_count  = 0;
    int         send_idle_pct   = 0;
    int         recv_stall_pct  = 0;

    // ------------------------------------------------------------------
    // predictor: register copy and assembler state
    // ------------------------------------------------------------------
    logic              xpose_on;
    logic signed [3:0] octave_shift;
    logic              cc_remap_on;
    logic [1:0]        asm_count;
    logic [7:0]        asm_first;
    logic [7:0]        asm_second;
    logic              sysex_open;
    logic              note_held    [NOTE_COUNT];
    logic [NOTE_W-1:0] note_shifted [NOTE_COUNT];

    // bytes a message takes, judged from its first byte alone
    function automatic msg_len_t message_size(input logic [7:0] b);
        if (b == SYSEX_START)                        return LEN_SYSEX;
        if (b == SONG_SELECT)                        return LEN_TWO;
        if (b == SONG_POSITION)                      return LEN_THREE;
        if (b[7:4] == NIB_SYSTEM)                    return LEN_ONE;
        if (b[7:4] == NIB_PROGRAM || b[7:4] == NIB_PRESSURE) return LEN_TWO;
        return LEN_THREE;
    endfunction

    // second byte after transposition / controller remap; updates the note table
    function automatic logic [7:0] remap_data_one(input logic [7:0] st,
                                                  input logic [7:0] d1);
        int         shifted;
        logic [7:0] res;
        res = d1;
        if (xpose_on) begin
            if (st[7:4] == NIB_NOTE_ON) begin
                shifted = int'(d1) + int'(octave_shift) * SEMITONES;
                if (shifted > NOTE_MAX) shifted = NOTE_MAX;
                if (shifted < 0)        shifted = 0;
                if (d1 < NOTE_COUNT) begin
                    note_held[d1[NOTE_W-1:0]]    = 1'b1;
                    note_shifted[d1[NOTE_W-1:0]] = shifted[NOTE_W-1:0];
                end
                res = shifted[7:0];
            end else if (st[7:4] == NIB_NOTE_OFF) begin
                if (d1 < NOTE_COUNT && note_held[d1[NOTE_W-1:0]]) begin
                    note_held[d1[NOTE_W-1:0]] = 1'b0;
                    res = {1'b0, note_shifted[d1[NOTE_W-1:0]]};
                end
            end else if (cc_remap_on && st == CC_CHAN0 && d1 <= CC_REMAP_MAX) begin
                res = d1 + CC_REMAP_ADD;
            end
        end
        return res;
    endfunction

    function automatic void expect_msg(input logic kind, input logic [7:0] st,
                                       input logic [7:0] d1, input logic [7:0] d2,
                                       input msg_len_t len, input logic last);
        result_t r;
        r.out_kind    = kind;
        r.status_byte = st;
        r.data_one    = d1;
        r.data_two    = d2;
        r.msg_length  = len;
        r.sysex_end   = last;
        expected_msgs.insert(expected_msgs.size(), r);
    endfunction

    // advance the assembler by one accepted byte
    function automatic void assemble_byte(input logic [7:0] b);
        msg_len_t sz;
        if (sysex_open) begin
            if (b == SYSEX_END) sysex_open = 1'b0;
            expect_msg(KIND_SYSEX, b, 8'h00, 8'h00, LEN_SYSEX, b == SYSEX_END);
        end else if (asm_count == 2'd0) begin
            sz = message_size(b);
            if (sz == LEN_SYSEX) begin
                sysex_open = 1'b1;
                expect_msg(KIND_SYSEX, b, 8'h00, 8'h00, LEN_SYSEX, 1'b0);
            end else if (sz == LEN_ONE) begin
                expect_msg(KIND_SHORT, b, 8'h00, 8'h00, LEN_ONE, 1'b0);
            end else begin
                asm_first = b;
                asm_count = 2'd1;
            end
        end else if (asm_count == 2'd1) begin
            if (message_size(asm_first) == LEN_TWO) begin
                asm_count = 2'd0;
                expect_msg(KIND_SHORT, asm_first, remap_data_one(asm_first, b),
                           8'h00, LEN_TWO, 1'b0);
            end else begin
                asm_second = b;
                asm_count  = 2'd2;
            end
        end else begin
            asm_count = 2'd0;
            expect_msg(KIND_SHORT, asm_first, remap_data_one(asm_first, asm_second),
                       b, LEN_THREE, 1'b0);
        end
    endfunction

    // ------------------------------------------------------------------
    // mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_error(input string what);
        if (mismatch_count < MAX_ERR_LINES)
            $display("ERROR @%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%02h, expected 0x%02h", name, got, want));
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued bytes, random sender gaps
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                assemble_byte(s_in_byte);
                bytes_sent++;
            end
            // only move on once the current byte is gone (or none was up)
            if (!s_valid || s_ready) begin
                if (midi_bytes_out.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_in_byte <= midi_bytes_out.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, compares each result transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_msgs.size() == 0) begin
                    report_error($sformatf("unexpected result, status 0x%02h",
                                           m_status_byte));
                end else begin
                    want = expected_msgs.pop_front();
                    check_field("out_kind",    8'(m_out_kind),   8'(want.out_kind));
                    check_field("status_byte", m_status_byte,    want.status_byte);
                    check_field("data_one",    m_data_one,       want.data_one);
                    check_field("data_two",    m_data_two,       want.data_two);
                    check_field("msg_length",  8'(m_msg_length), 8'(want.msg_length));
                    check_field("sysex_end",   8'(m_sysex_end),  8'(want.sysex_end));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void queue_byte(input logic [7:0] b);
        midi_bytes_out.insert(midi_bytes_out.size(), b);
        bytes_queued++;
    endfunction

    // register write; issued only after a drain, when no byte or result is in flight
    task automatic write_register(input logic [1:0] idx, input logic [3:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TRANSPOSE_ACTIVE:  xpose_on     = value[0];
            CFG_TRANSPOSE_OCTAVES: octave_shift = value;
            CFG_CONTROLLER_STREAM: cc_remap_on  = value[0];
            default: ;  // spare index, write has no effect
        endcase
    endtask

    // hold off until every byte is taken and every result has come back,
    // then let the core settle before going on
    task automatic wait_drained();
        while (bytes_sent != bytes_queued || expected_msgs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed traffic with random content, some raw noise
    task automatic queue_midi_traffic(input int count);
        int         stop_at;
        int         pick;
        int         n;
        logic [3:0] ch;
        logic [7:0] st;
        msg_len_t   sz;
        stop_at = bytes_queued + count;
        while (bytes_queued < stop_at) begin
            pick = $urandom_range(99);
            ch   = 4'($urandom_range(15));
            if (pick < 30) begin
                queue_byte({NIB_NOTE_ON, ch});
                queue_byte(($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
                                                    : NOTE_POOL[$urandom_range(7)]);
                queue_byte(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(1, 127)));
            end else if (pick < 50) begin
                queue_byte({NIB_NOTE_OFF, ch});
                queue_byte(($urandom_range(7) == 0) ? 8'($urandom_range(128, 255))
                                                    : NOTE_POOL[$urandom_range(7)]);
                queue_byte(8'($urandom_range(127)));
            end else if (pick < 62) begin
                queue_byte($urandom_range(1) ? CC_CHAN0 : {CC_CHAN0[7:4], ch});
                queue_byte(($urandom_range(5) == 0) ? 8'($urandom_range(255))
                                                    : 8'($urandom_range(15)));
                queue_byte(8'($urandom_range(255)));
            end else if (pick < 70) begin
                queue_byte({($urandom_range(1) ? NIB_PROGRAM : NIB_PRESSURE), ch});
                queue_byte(8'($urandom_range(255)));
            end else if (pick < 80) begin
                // system common and realtime, any of F1..FF
                st = {NIB_SYSTEM, 4'($urandom_range(1, 15))};
                sz = message_size(st);
                queue_byte(st);
                for (n = 1; n < int'(sz); n++) queue_byte(8'($urandom_range(127)));
            end else if (pick < 90) begin
                queue_byte(SYSEX_START);
                for (n = $urandom_range(6); n > 0; n--) begin
                    st = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                  : 8'($urandom_range(127));
                    if (st == SYSEX_END) st = SYSEX_START;
                    queue_byte(st);
                end
                queue_byte(SYSEX_END);
            end else begin
                queue_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // one register setting and idling pattern; drains halfway so the sender
    // sits idle until every outstanding result has been delivered
    task automatic run_setting(input int idle_pct, input int stall_pct,
                               input logic act, input logic [3:0] oct,
                               input logic cc_on, input int count);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_register(CFG_TRANSPOSE_ACTIVE,  {3'b000, act});
        write_register(CFG_TRANSPOSE_OCTAVES, oct);
        write_register(CFG_CONTROLLER_STREAM, {3'b000, cc_on});
        queue_midi_traffic(count / 2);
        wait_drained();
        queue_midi_traffic(count - count / 2);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        xpose_on     = 1'b0;
        octave_shift = 4'sd0;
        cc_remap_on  = 1'b0;
        asm_count    = 2'd0;
        asm_first    = 8'h00;
        asm_second   = 8'h00;
        sysex_open   = 1'b0;
        foreach (note_held[i]) begin
            note_held[i]    = 1'b0;
            note_shifted[i] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: parsing corners at reset settings
        foreach (PLAIN_BYTES[i]) queue_byte(PLAIN_BYTES[i]);
        wait_drained();

        // directed: transposition corners, octave at its negative extreme;
        // the spare index write must change nothing
        write_register(CFG_TRANSPOSE_ACTIVE,  4'h1);
        write_register(CFG_TRANSPOSE_OCTAVES, 4'h8);
        write_register(CFG_CONTROLLER_STREAM, 4'h1);
        write_register(CFG_SPARE_INDEX,       4'hF);
        foreach (XPOSE_BYTES[i]) queue_byte(XPOSE_BYTES[i]);
        wait_drained();

        // random traffic across idling patterns and settings
        run_setting(0,  0,  1'b1, 4'h4, 1'b1, ITEMS_PER_SET);   // +4 octaves
        run_setting(74, 0,  1'b1, 4'hC, 1'b0, ITEMS_PER_SET);   // -4 octaves
        run_setting(0,  74, 1'b0, 4'($urandom_range(15)), 1'b1, ITEMS_PER_SET);
        run_setting(28, 28, 1'b1, 4'h7, 1'b1, ITEMS_PER_SET);   // out of range +7

        if (expected_msgs.size() != 0)
            report_error("results still outstanding at end of run");
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog for a hung handshake
    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ midi_message_assembler_transposer_core.f @@
src/mmat_pkg.sv
src/midi_message_assembler_transposer_core.sv
verif/midi_message_assembler_transposer_core_test.sv
